// File: hw/rtl/ucalc_pkg.sv
// ----------------------------------------------------------------------------
// ucalc_pkg
// shared constants, types and state codes of the utilization throttle block
// ----------------------------------------------------------------------------
`default_nettype none

package ucalc_pkg;

  localparam int unsigned TickW    = 64;
  localparam int unsigned CntW     = $clog2(TickW);
  localparam int unsigned PctW     = 7;
  localparam int unsigned PauseW   = 17;

  localparam logic [PctW-1:0]   PctScale   = 7'd100;
  localparam logic [PctW-1:0]   LimitReset = 7'd80;
  localparam logic [PauseW-1:0] UsPerPct   = 17'd1000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DIV,
    ST_DONE
  } ucalc_state_e;

  // status gathered by the serial delta pass
  typedef struct packed {
    logic primed;    // previous user counter was nonzero
    logic busy_ge;   // busy >= total
    logic total_nz;  // total != 0
  } ucalc_flags_t;

endpackage

`default_nettype wire

// File: hw/rtl/utilization_throttle_calc.sv
// ----------------------------------------------------------------------------
// utilization_throttle_calc
// busy share of tick counter deltas and pause request above a load limit
// ----------------------------------------------------------------------------
//  channel | handshake                      | payload
//  --------+--------------------------------+------------------------------------
//  in      | in_valid_i / in_stall_o        | user, nice, system, idle ticks (64b)
//  out     | out_valid_o / out_stall_i      | load_percent, pause_us, pause_flag
//  cfg     | cfg_valid_i / cfg_ready_o      | cfg_data_i -> load_limit (7b)
//
// one transaction in processing, a second may wait in the result register
// a transaction runs the bit-serial delta pass, then the scaled ratio iterations,
// then registers its result; the next input is taken once the block is idle
// the result register frees the input side while a result waits on out_stall_i
// reset clears the stored snapshot and sets load_limit to 80
// ----------------------------------------------------------------------------
`default_nettype none

module utilization_throttle_calc (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [ucalc_pkg::TickW-1:0]  user_ticks_i,
  input  wire logic [ucalc_pkg::TickW-1:0]  nice_ticks_i,
  input  wire logic [ucalc_pkg::TickW-1:0]  system_ticks_i,
  input  wire logic [ucalc_pkg::TickW-1:0]  idle_ticks_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [ucalc_pkg::PctW-1:0]   load_percent_o,
  output logic      [ucalc_pkg::PauseW-1:0] pause_us_o,
  output logic                              pause_flag_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [ucalc_pkg::PctW-1:0]   cfg_data_i
);
  import ucalc_pkg::*;

  ucalc_state_e     state_q, state_d;
  logic [CntW-1:0]  cnt_q;
  logic [PctW-1:0]  limit_q;
  logic             out_valid_q;
  logic [PctW-1:0]  load_q;
  logic [PauseW-1:0] pause_q;
  logic             in_acc;
  logic             shift;
  logic             div_start;
  logic             div_done;
  logic             out_free;
  logic             emit;
  logic [TickW-1:0] busy;
  logic [TickW-1:0] total;
  ucalc_flags_t     flags;
  logic [PctW-1:0]  quot;
  logic [PctW-1:0]  load;
  logic [PctW-1:0]  over;
  logic [PauseW-1:0] pause;

  ucalc_serial u_serial (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (in_acc),
    .shift_i        (shift),
    .user_ticks_i   (user_ticks_i),
    .nice_ticks_i   (nice_ticks_i),
    .system_ticks_i (system_ticks_i),
    .idle_ticks_i   (idle_ticks_i),
    .busy_o         (busy),
    .total_o        (total),
    .flags_o        (flags)
  );

  ucalc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (busy),
    .den_i   (total),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign shift     = (state_q == ST_SHIFT);
  assign div_start = shift && (cnt_q == CntW'(TickW - 1));

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    emit       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (div_start) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (!flags.primed || !flags.total_nz) begin
      load = '0;
    end else if (flags.busy_ge) begin
      load = PctScale;
    end else begin
      load = quot;
    end
    over  = load - limit_q;
    pause = (load > limit_q) ? PauseW'(over) * UsPerPct : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc) begin
      cnt_q <= '0;
    end else if (shift) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      load_q  <= load;
      pause_q <= pause;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign load_percent_o = load_q;
  assign pause_us_o     = pause_q;
  assign pause_flag_o   = (pause_q != '0);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> load_percent_o <= PctScale)
    else $error("load above full scale");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   div_done |-> state_q == ST_DIV)
    else $error("divider finished outside divide phase");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_acc |=> state_q == ST_SHIFT && cnt_q == '0)
    else $error("serial pass did not start after input transaction");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   emit |=> out_valid_o && state_q == ST_IDLE)
    else $error("result not presented");

endmodule

`default_nettype wire

// File: hw/rtl/ucalc_serial.sv
// ----------------------------------------------------------------------------
// ucalc_serial
// bit-serial delta unit: one bit per cycle while shift_i is high, lsb first,
// forms busy and total and replaces the stored snapshot with the new one
// ----------------------------------------------------------------------------
`default_nettype none

module ucalc_serial (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  wire logic                        shift_i,
  input  wire logic [ucalc_pkg::TickW-1:0] user_ticks_i,
  input  wire logic [ucalc_pkg::TickW-1:0] nice_ticks_i,
  input  wire logic [ucalc_pkg::TickW-1:0] system_ticks_i,
  input  wire logic [ucalc_pkg::TickW-1:0] idle_ticks_i,
  output logic      [ucalc_pkg::TickW-1:0] busy_o,
  output logic      [ucalc_pkg::TickW-1:0] total_o,
  output ucalc_pkg::ucalc_flags_t          flags_o
);
  import ucalc_pkg::*;

  logic [TickW-1:0] cur_u_q, cur_n_q, cur_s_q, cur_i_q;
  logic [TickW-1:0] prev_u_q, prev_n_q, prev_s_q, prev_i_q;
  logic [TickW-1:0] busy_q, total_q;
  logic             bw_u_q, bw_n_q, bw_s_q, bw_i_q;
  logic             bw_u_d, bw_n_d, bw_s_d, bw_i_d;
  logic [1:0]       bc_q;
  logic             tc_q;
  ucalc_flags_t     flags_q, flags_d;
  logic             du, dn, ds, di;
  logic [2:0]       bsum;
  logic [1:0]       tsum;

  function automatic logic [1:0] sub_bit(input logic a, input logic b, input logic bw);
    logic d;
    logic bo;
    d  = a ^ b ^ bw;
    bo = (~a & b) | (~(a ^ b) & bw);
    return {bo, d};
  endfunction

  always_comb begin
    {bw_u_d, du} = sub_bit(cur_u_q[0], prev_u_q[0], bw_u_q);
    {bw_n_d, dn} = sub_bit(cur_n_q[0], prev_n_q[0], bw_n_q);
    {bw_s_d, ds} = sub_bit(cur_s_q[0], prev_s_q[0], bw_s_q);
    {bw_i_d, di} = sub_bit(cur_i_q[0], prev_i_q[0], bw_i_q);
    bsum = {2'b00, du} + {2'b00, dn} + {2'b00, ds} + {1'b0, bc_q};
    tsum = {1'b0, bsum[0]} + {1'b0, di} + {1'b0, tc_q};
    flags_d = flags_q;
    flags_d.primed   = flags_q.primed | prev_u_q[0];
    flags_d.total_nz = flags_q.total_nz | tsum[0];
    if (bsum[0] != tsum[0]) begin
      flags_d.busy_ge = bsum[0];
    end
  end

  // snapshot store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_u_q <= '0;
      prev_n_q <= '0;
      prev_s_q <= '0;
      prev_i_q <= '0;
    end else if (shift_i) begin
      prev_u_q <= {cur_u_q[0], prev_u_q[TickW-1:1]};
      prev_n_q <= {cur_n_q[0], prev_n_q[TickW-1:1]};
      prev_s_q <= {cur_s_q[0], prev_s_q[TickW-1:1]};
      prev_i_q <= {cur_i_q[0], prev_i_q[TickW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_u_q  <= 1'b0;
      bw_n_q  <= 1'b0;
      bw_s_q  <= 1'b0;
      bw_i_q  <= 1'b0;
      bc_q    <= '0;
      tc_q    <= 1'b0;
      flags_q <= '0;
    end else if (load_i) begin
      bw_u_q  <= 1'b0;
      bw_n_q  <= 1'b0;
      bw_s_q  <= 1'b0;
      bw_i_q  <= 1'b0;
      bc_q    <= '0;
      tc_q    <= 1'b0;
      flags_q <= '{primed: 1'b0, busy_ge: 1'b1, total_nz: 1'b0};
    end else if (shift_i) begin
      bw_u_q  <= bw_u_d;
      bw_n_q  <= bw_n_d;
      bw_s_q  <= bw_s_d;
      bw_i_q  <= bw_i_d;
      bc_q    <= bsum[2:1];
      tc_q    <= tsum[1];
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cur_u_q <= user_ticks_i;
      cur_n_q <= nice_ticks_i;
      cur_s_q <= system_ticks_i;
      cur_i_q <= idle_ticks_i;
    end else if (shift_i) begin
      cur_u_q <= {1'b0, cur_u_q[TickW-1:1]};
      cur_n_q <= {1'b0, cur_n_q[TickW-1:1]};
      cur_s_q <= {1'b0, cur_s_q[TickW-1:1]};
      cur_i_q <= {1'b0, cur_i_q[TickW-1:1]};
      busy_q  <= {bsum[0], busy_q[TickW-1:1]};
      total_q <= {tsum[0], total_q[TickW-1:1]};
    end
  end

  assign busy_o  = busy_q;
  assign total_o = total_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

// File: hw/rtl/ucalc_div.sv
// ----------------------------------------------------------------------------
// ucalc_div
// iterative scaled ratio: floor(num * 100 / den) for num < den, one quotient
// bit per cycle, except for an add-numerator step at each set bit of the scale
// ----------------------------------------------------------------------------
`default_nettype none

module ucalc_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [ucalc_pkg::TickW-1:0] num_i,
  input  wire logic [ucalc_pkg::TickW-1:0] den_i,
  output logic                             done_o,
  output logic      [ucalc_pkg::PctW-1:0]  quot_o
);
  import ucalc_pkg::*;

  localparam int unsigned BitW = $clog2(PctW);

  logic                busy_q;
  logic [BitW-1:0]     bit_q;
  logic                add_q;
  logic [TickW-1:0]    rem_q;
  logic [PctW-1:0]     quot_q;
  logic [TickW:0]      two_r;
  logic [TickW+1:0]    dbl_diff;
  logic [TickW:0]      r_plus;
  logic [TickW+1:0]    add_diff;
  logic                last;

  always_comb begin
    two_r    = {rem_q, 1'b0};
    dbl_diff = {1'b0, two_r} - {2'b00, den_i};
    r_plus   = {1'b0, rem_q} + {1'b0, num_i};
    add_diff = {1'b0, r_plus} - {2'b00, den_i};
    last     = (bit_q == '0) && (add_q || !PctScale[bit_q]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bit_q  <= '0;
      add_q  <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      bit_q  <= BitW'(PctW - 1);
      add_q  <= 1'b0;
    end else if (busy_q) begin
      if (!add_q && PctScale[bit_q]) begin
        add_q <= 1'b1;
      end else begin
        add_q <= 1'b0;
        if (last) begin
          busy_q <= 1'b0;
        end else begin
          bit_q <= bit_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      if (!add_q) begin
        // doubling step
        quot_q <= {quot_q[PctW-2:0], ~dbl_diff[TickW+1]};
        rem_q  <= dbl_diff[TickW+1] ? two_r[TickW-1:0] : dbl_diff[TickW-1:0];
      end else begin
        // add-numerator step
        quot_q <= quot_q + {{(PctW-1){1'b0}}, ~add_diff[TickW+1]};
        rem_q  <= add_diff[TickW+1] ? r_plus[TickW-1:0] : add_diff[TickW-1:0];
      end
    end
  end

  assign done_o = busy_q && last;
  assign quot_o = quot_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy_q)
    else $error("divider still busy after done");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_q && !done_o)
    else $error("divider did not start");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench for utilization_throttle_calc
// drives tick counter snapshots through the input channel under random bursts
// and gaps, stalls the result channel on its own pattern, and checks the load
// percent, pause time and pause flag of every result against a predictor that
// keeps its own copy of the previous snapshot and the load limit. the run
// steps through several load limits, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
  import ucalc_pkg::*;

  localparam int CycleLimit = 1_000_000;

  typedef logic [TickW-1:0] tick_t;

  typedef struct packed {
    tick_t user;
    tick_t nice;
    tick_t sys;
    tick_t idle;
  } snap_t;

  typedef struct packed {
    logic [PctW-1:0]   load;
    logic [PauseW-1:0] pause;
    logic              flag;
  } throttle_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  tick_t             user_ticks_i = '0;
  tick_t             nice_ticks_i = '0;
  tick_t             system_ticks_i = '0;
  tick_t             idle_ticks_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [PctW-1:0]   load_percent_o;
  logic [PauseW-1:0] pause_us_o;
  logic              pause_flag_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [PctW-1:0]   cfg_data_i = '0;

  snap_t     pending_snaps[$];
  throttle_t expected_throttle[$];
  snap_t     gen_snap = '0;
  snap_t     last_snap = '0;
  logic [PctW-1:0] limit_q = LimitReset;
  int        fail_count = 0;
  int        cycle_count = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_tick = 0;
  int        stall_mode = 0;

  utilization_throttle_calc uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .user_ticks_i   (user_ticks_i),
    .nice_ticks_i   (nice_ticks_i),
    .system_ticks_i (system_ticks_i),
    .idle_ticks_i   (idle_ticks_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .load_percent_o (load_percent_o),
    .pause_us_o     (pause_us_o),
    .pause_flag_o   (pause_flag_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // expected load and pause for one accepted snapshot
  task automatic predict_throttle(input snap_t s);
    tick_t           busy;
    tick_t           total;
    logic [71:0]     scaled;
    logic [PctW-1:0] load;
    throttle_t       r;
    load = '0;
    if (last_snap.user != '0) begin
      busy  = (s.user - last_snap.user) + (s.nice - last_snap.nice) + (s.sys - last_snap.sys);
      total = busy + (s.idle - last_snap.idle);
      if (total != '0) begin
        if (busy >= total) begin
          load = PctScale;
        end else begin
          scaled = {8'd0, busy} * 72'd100;
          load   = PctW'(scaled / {8'd0, total});
        end
      end
    end
    last_snap = s;
    r.load  = load;
    r.pause = '0;
    if (load > limit_q) begin
      r.pause = PauseW'(load - limit_q) * UsPerPct;
    end
    r.flag = (r.pause != '0);
    expected_throttle.push_back(r);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_throttle('{user_ticks_i, nice_ticks_i, system_ticks_i, idle_ticks_i});
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_snaps.size() != 0) begin
          snap_t s;
          s = pending_snaps.pop_front();
          user_ticks_i   <= s.user;
          nice_ticks_i   <= s.nice;
          system_ticks_i <= s.sys;
          idle_ticks_i   <= s.idle;
          in_valid_i     <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100)
                                                   : $urandom_range(0, 3);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void note_mismatch(input string field, input longint unsigned want,
                                        input longint unsigned got);
    fail_count++;
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endfunction

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_throttle.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transaction, load_percent %0d", $time, load_percent_o);
        end else begin
          throttle_t want;
          want = expected_throttle.pop_front();
          if (load_percent_o !== want.load) note_mismatch("load_percent", want.load,
                                                          load_percent_o);
          if (pause_us_o !== want.pause) note_mismatch("pause_us", want.pause, pause_us_o);
          if (pause_flag_o !== want.flag) note_mismatch("pause_flag", want.flag,
                                                        pause_flag_o);
        end
      end
      stall_tick = stall_tick + 1;
      if (stall_tick % 256 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= 1'($urandom_range(0, 1));
        2: out_stall_i <= (stall_tick % 4 != 0);
        default: out_stall_i <= (stall_tick % 40 < 30);
      endcase
    end
  end

  function automatic tick_t rand_tick();
    return {$urandom, $urandom};
  endfunction

  function automatic tick_t rand_delta();
    return rand_tick() >> $urandom_range(0, 63);
  endfunction

  task automatic push_snap(input tick_t u, input tick_t n, input tick_t s, input tick_t i);
    gen_snap = '{u, n, s, i};
    pending_snaps.push_back(gen_snap);
  endtask

  task automatic push_step(input tick_t du, input tick_t dn, input tick_t ds, input tick_t di);
    push_snap(gen_snap.user + du, gen_snap.nice + dn, gen_snap.sys + ds, gen_snap.idle + di);
  endtask

  task automatic push_random(input int count);
    tick_t m;
    tick_t busy_part;
    tick_t a;
    tick_t b;
    int    k;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: push_step('0, '0, '0, '0);
        1: push_snap('0, rand_tick(), rand_tick(), rand_tick());
        2: push_snap(rand_tick(), rand_tick(), rand_tick(), rand_tick());
        3, 4, 5: push_step(rand_delta(), rand_delta(), rand_delta(), rand_delta());
        default: begin
          // deltas with an exact busy share of k percent
          k = $urandom_range(0, 100);
          m = (rand_tick() >> $urandom_range(8, 63)) + 1;
          busy_part = m * k;
          a = rand_tick() % (busy_part + 1);
          b = rand_tick() % (busy_part - a + 1);
          push_step(a, b, busy_part - a - b, m * (100 - k));
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    wait (pending_snaps.size() == 0 && !in_valid_i && expected_throttle.size() == 0);
  endtask

  task automatic write_limit(input logic [PctW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_q = value;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_snap('0, '0, '0, '0);
    push_snap(64'd1, '0, '0, '0);
    push_snap(64'd1, '0, '0, '0);
    push_step(64'd100, '0, '0, '0);
    push_step('0, '0, '0, 64'd100);
    push_step(64'd81, '0, '0, 64'd19);
    push_step('0, 64'd40, 64'd40, 64'd20);
    push_step(64'd1, '0, '0, 64'd2);
    push_snap('1, '1, '1, '1);
    push_step(64'hFFFF_FFFF_FFFF_FFF6, '0, '0, 64'd20);
    push_step(64'h8000_0000_0000_0000, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF);
    push_step(64'd99 << 56, '0, '0, 64'd1 << 56);
    push_snap('0, 64'd5, 64'd5, 64'd5);
    push_step(64'd10, 64'd10, 64'd10, 64'd10);
    push_step(64'd10, 64'd10, 64'd10, 64'd10);
    push_snap('1, '0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    push_step(64'd1, 64'd1, 64'd1, '0);
    push_snap(64'h8000_0000_0000_0000, '1, '0, '1);
    push_random(200);
    wait_drained();

    write_limit(7'd0);
    push_random(215);
    wait_drained();
    write_limit(7'd127);
    push_random(215);
    wait_drained();
    write_limit(7'd10);
    push_random(215);
    wait_drained();
    write_limit(7'd95);
    push_random(215);
    wait_drained();
    write_limit(7'd100);
    push_random(215);
    wait_drained();
    write_limit(7'd81);
    push_random(215);
    wait_drained();
    repeat (2) begin
      write_limit(PctW'($urandom_range(0, 127)));
      push_random(225);
      wait_drained();
    end

    repeat (100) @(posedge clk_i);
    if (expected_throttle.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
